FILE: sv/sact_pkg.sv
// Shared types and constants for the set-associative cache tag lookup.
// No dependencies; used by sact_row_mem and set_assoc_cache_tag_lookup.
package sact_pkg;

  // Default sizing of the tag store
  localparam int MAX_SETS   = 64;
  localparam int MAX_WAYS   = 8;
  localparam int STAMP_BITS = 32;

  // Fixed field widths
  localparam int TAG_W    = 32;
  localparam int ADDR_W   = 32;
  localparam int WAY_O_W  = 3;
  localparam int TOTAL_W  = 32;
  localparam int WAY_CNT_W = 5;   // holds a way count up to 31
  localparam int IDX_VAL_W = 7;   // index_bits register can select up to 7 bits

  // Configuration register map (word index)
  typedef enum logic [1:0] {
    REG_POLICY      = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_INDEX_BITS  = 2'd2,
    REG_ACTIVE_WAYS = 2'd3
  } sact_reg_e;

  // Replacement policy codes
  typedef enum logic {
    POLICY_LRU  = 1'b0,
    POLICY_FIFO = 1'b1
  } sact_policy_e;

  // Lookup sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOKUP,
    ST_SCAN,
    ST_DONE
  } sact_state_e;

endpackage

FILE: sv/sact_row_mem.sv
// One-row-per-set synchronous memory for the cache tag store, one read port and
// one write port, read data registered. Keeps a written flag per row so that
// rows never written since reset read as empty. Uses sact_pkg for defaults.
module sact_row_mem #(
  parameter int Depth = sact_pkg::MAX_SETS,
  parameter int Width = sact_pkg::MAX_WAYS * (1 + sact_pkg::TAG_W + 2 * sact_pkg::STAMP_BITS),
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  output logic [Width-1:0] rd_data_o,
  output logic             rd_row_valid_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] row_written_q;
  logic [Width-1:0] rd_data_q;
  logic             rd_row_valid_q;

  // Write and read the row array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Track rows written since reset; the sequencer never reads and writes one cycle together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_written_q  <= '0;
      rd_row_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_row_valid_q <= row_written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o      = rd_data_q;
  assign rd_row_valid_o = rd_row_valid_q;

endmodule

FILE: sv/set_assoc_cache_tag_lookup.sv
// Set-associative cache tag lookup with LRU or FIFO replacement; top level.
// Depends on sact_pkg and sact_row_mem.
//
// A request is taken when start is high and busy is low. A hit, or a miss that
// fills an empty way, passes through the row read, the tag compare and the
// write-back, and the next request can be accepted in the write-back cycle; a
// miss into a full set adds a victim compare that walks the stamps of the active
// ways beyond the first, one way per cycle. The whole set lives in one memory
// row, read in a single access and written back once. The result shows on the
// output ports for one cycle with done_o, the cycle after the write-back; the
// receiver cannot stall it. All lines start invalid after reset with no clearing
// pass.
module set_assoc_cache_tag_lookup #(
  parameter int MaxSets   = sact_pkg::MAX_SETS,
  parameter int MaxWays   = sact_pkg::MAX_WAYS,
  parameter int StampBits = sact_pkg::STAMP_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB-style configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // Request
  input  logic                             start,
  output logic                             busy,
  input  logic [sact_pkg::ADDR_W-1:0]      address_i,
  // Result
  output logic                             done_o,
  output logic                             hit_o,
  output logic [sact_pkg::WAY_O_W-1:0]     way_o,
  output logic                             replaced_valid_o,
  output logic [sact_pkg::TOTAL_W-1:0]     hit_total_o,
  output logic [sact_pkg::TOTAL_W-1:0]     miss_total_o
);

  localparam int SetW  = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  localparam int WayW  = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int TagW  = sact_pkg::TAG_W;
  localparam int CntW  = sact_pkg::WAY_CNT_W;
  localparam int IdxW  = sact_pkg::IDX_VAL_W;
  localparam int RowW  = MaxWays * (1 + TagW + 2 * StampBits);

  // Configuration registers
  logic       policy_q;
  logic [3:0] offset_bits_q;
  logic [2:0] index_bits_q;
  logic [3:0] active_ways_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q      <= sact_pkg::POLICY_LRU;
      offset_bits_q <= 4'd4;
      index_bits_q  <= 3'd1;
      active_ways_q <= 4'd2;
    end else if (cfg_wr) begin
      case (sact_pkg::sact_reg_e'(paddr[3:2]))
        sact_pkg::REG_POLICY:      policy_q      <= pwdata[0];
        sact_pkg::REG_OFFSET_BITS: offset_bits_q <= pwdata[3:0];
        sact_pkg::REG_INDEX_BITS:  index_bits_q  <= pwdata[2:0];
        sact_pkg::REG_ACTIVE_WAYS: active_ways_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (sact_pkg::sact_reg_e'(paddr[3:2]))
      sact_pkg::REG_POLICY:      prdata = {31'd0, policy_q};
      sact_pkg::REG_OFFSET_BITS: prdata = {28'd0, offset_bits_q};
      sact_pkg::REG_INDEX_BITS:  prdata = {29'd0, index_bits_q};
      sact_pkg::REG_ACTIVE_WAYS: prdata = {28'd0, active_ways_q};
      default:                   prdata = '0;
    endcase
  end

  // Clamp associativity to the range [1, MaxWays]
  logic [CntW-1:0] ways_eff;

  always_comb begin
    if (active_ways_q == 4'd0) begin
      ways_eff = CntW'(1);
    end else if ({1'b0, active_ways_q} > CntW'(MaxWays)) begin
      ways_eff = CntW'(MaxWays);
    end else begin
      ways_eff = {1'b0, active_ways_q};
    end
  end

  // Split the address into set and tag
  logic [sact_pkg::ADDR_W-1:0] addr_shifted;
  logic [IdxW-1:0]             idx_mask;
  logic [IdxW-1:0]             idx_val;
  logic [SetW+IdxW-1:0]        idx_ext;
  logic [SetW-1:0]             set_n;
  logic [4:0]                  tag_shift;
  logic [TagW-1:0]             tag_n;

  assign addr_shifted = address_i >> offset_bits_q;
  assign idx_mask     = IdxW'((8'd1 << index_bits_q) - 8'd1);
  assign idx_val      = addr_shifted[IdxW-1:0] & idx_mask;
  assign idx_ext      = {{SetW{1'b0}}, idx_val};
  assign set_n        = (MaxSets == 1) ? '0 : idx_ext[SetW-1:0];
  assign tag_shift    = {1'b0, offset_bits_q} + {2'b00, index_bits_q};
  assign tag_n        = TagW'(address_i >> tag_shift);

  // Sequencer state
  sact_pkg::sact_state_e state_q, state_d;
  logic accept;
  logic mem_rd_en;
  logic mem_wr_en;

  assign accept = start & ~busy;

  // Row memory interface
  logic [RowW-1:0] rd_row;
  logic [RowW-1:0] wr_row;
  logic            rd_row_valid;
  logic [SetW-1:0] set_q;

  logic [MaxWays-1:0]                rd_valid;
  logic [MaxWays-1:0][TagW-1:0]      rd_tag;
  logic [MaxWays-1:0][StampBits-1:0] rd_lru;
  logic [MaxWays-1:0][StampBits-1:0] rd_load;
  logic [MaxWays-1:0]                wr_valid;
  logic [MaxWays-1:0][TagW-1:0]      wr_tag;
  logic [MaxWays-1:0][StampBits-1:0] wr_lru;
  logic [MaxWays-1:0][StampBits-1:0] wr_load;

  assign {rd_valid, rd_tag, rd_lru, rd_load} = rd_row;
  assign wr_row = {wr_valid, wr_tag, wr_lru, wr_load};

  sact_row_mem #(
    .Depth (MaxSets),
    .Width (RowW)
  ) u_row_mem (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rd_en_i        (mem_rd_en),
    .rd_addr_i      (set_q),
    .wr_en_i        (mem_wr_en),
    .wr_addr_i      (set_q),
    .wr_data_i      (wr_row),
    .rd_data_o      (rd_row),
    .rd_row_valid_o (rd_row_valid)
  );

  // Request registers
  logic [TagW-1:0]      tag_q;
  logic [StampBits-1:0] stamp_q;
  logic                 hit_q;
  logic                 repl_q;
  logic [WayW-1:0]      target_q;
  logic [WayW-1:0]      scan_idx_q;
  logic [StampBits-1:0] oldest_q;

  // Compare tags and find the lowest empty way
  logic [MaxWays-1:0]                eff_valid;
  logic [MaxWays-1:0]                way_match;
  logic [MaxWays-1:0]                way_empty;
  logic [MaxWays-1:0][StampBits-1:0] vict_stamp;
  logic                              hit_found;
  logic                              empty_found;
  logic [WayW-1:0]                   hit_way;
  logic [WayW-1:0]                   empty_way;

  assign eff_valid = rd_row_valid ? rd_valid : '0;

  always_comb begin
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_way     = '0;
    empty_way   = '0;
    for (int w = 0; w < MaxWays; w++) begin
      way_match[w]  = eff_valid[w] && (CntW'(w) < ways_eff) && (rd_tag[w] == tag_q);
      way_empty[w]  = !eff_valid[w] && (CntW'(w) < ways_eff);
      vict_stamp[w] = (policy_q == sact_pkg::POLICY_FIFO) ? rd_load[w] : rd_lru[w];
    end
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (way_match[w]) begin
        hit_found = 1'b1;
        hit_way   = WayW'(w);
      end
      if (way_empty[w]) begin
        empty_found = 1'b1;
        empty_way   = WayW'(w);
      end
    end
  end

  // Victim scan: one way per cycle, strict less-than keeps the lowest way
  logic [StampBits-1:0] scan_stamp;
  logic                 scan_less;
  logic                 scan_last;
  logic                 lookup_done;

  assign scan_stamp  = vict_stamp[scan_idx_q];
  assign scan_less   = scan_stamp < oldest_q;
  assign scan_last   = CntW'(scan_idx_q) == (ways_eff - CntW'(1));
  assign lookup_done = hit_found | empty_found | (ways_eff == CntW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sact_pkg::ST_IDLE:   if (accept) state_d = sact_pkg::ST_READ;
      sact_pkg::ST_READ:   state_d = sact_pkg::ST_LOOKUP;
      sact_pkg::ST_LOOKUP: state_d = lookup_done ? sact_pkg::ST_DONE : sact_pkg::ST_SCAN;
      sact_pkg::ST_SCAN:   if (scan_last) state_d = sact_pkg::ST_DONE;
      sact_pkg::ST_DONE:   state_d = accept ? sact_pkg::ST_READ : sact_pkg::ST_IDLE;
      default:             state_d = sact_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy      = 1'b1;
    mem_rd_en = 1'b0;
    mem_wr_en = 1'b0;
    case (state_q)
      sact_pkg::ST_IDLE: busy = 1'b0;
      sact_pkg::ST_READ: mem_rd_en = 1'b1;
      sact_pkg::ST_DONE: begin
        busy      = 1'b0;
        mem_wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sact_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Build the write-back row
  always_comb begin
    wr_valid = eff_valid;
    wr_tag   = rd_tag;
    wr_lru   = rd_lru;
    wr_load  = rd_load;
    if (hit_q) begin
      if (policy_q == sact_pkg::POLICY_LRU) begin
        wr_lru[target_q] = stamp_q;
      end
    end else begin
      wr_valid[target_q] = 1'b1;
      wr_tag[target_q]   = tag_q;
      wr_lru[target_q]   = stamp_q;
      wr_load[target_q]  = stamp_q;
    end
  end

  // Capture the request and resolve the target way
  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_n;
      tag_q <= tag_n;
    end
    case (state_q)
      sact_pkg::ST_LOOKUP: begin
        if (hit_found) begin
          hit_q    <= 1'b1;
          repl_q   <= 1'b0;
          target_q <= hit_way;
        end else if (empty_found) begin
          hit_q    <= 1'b0;
          repl_q   <= 1'b0;
          target_q <= empty_way;
        end else begin
          hit_q      <= 1'b0;
          repl_q     <= 1'b1;
          target_q   <= '0;
          oldest_q   <= vict_stamp[0];
          scan_idx_q <= WayW'(1);
        end
      end
      sact_pkg::ST_SCAN: begin
        if (scan_less) begin
          target_q <= scan_idx_q;
          oldest_q <= scan_stamp;
        end
        scan_idx_q <= scan_idx_q + WayW'(1);
      end
      default: ;
    endcase
  end

  // Access clock and saturating totals
  logic [sact_pkg::TOTAL_W-1:0] hits_q;
  logic [sact_pkg::TOTAL_W-1:0] misses_q;
  logic                         done_q;
  logic                         out_hit_q;
  logic                         out_repl_q;
  logic [WayW+sact_pkg::WAY_O_W-1:0] out_way_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= (state_q == sact_pkg::ST_DONE);
      if (accept && (stamp_q != {StampBits{1'b1}})) begin
        stamp_q <= stamp_q + StampBits'(1);
      end
      if (state_q == sact_pkg::ST_DONE) begin
        if (hit_q) begin
          if (hits_q != '1) hits_q <= hits_q + 32'd1;
        end else begin
          if (misses_q != '1) misses_q <= misses_q + 32'd1;
        end
      end
    end
  end

  // Hold the result fields for the strobe cycle
  always_ff @(posedge clk_i) begin
    if (state_q == sact_pkg::ST_DONE) begin
      out_hit_q  <= hit_q;
      out_repl_q <= repl_q;
      out_way_q  <= {{sact_pkg::WAY_O_W{1'b0}}, target_q};
    end
  end

  assign done_o           = done_q;
  assign hit_o            = out_hit_q;
  assign replaced_valid_o = out_repl_q;
  assign way_o            = out_way_q[sact_pkg::WAY_O_W-1:0];
  assign hit_total_o      = hits_q;
  assign miss_total_o     = misses_q;

endmodule

FILE: tb/sv/tb_set_assoc_cache_tag_lookup.sv
// Self-checking testbench for set_assoc_cache_tag_lookup: drives lookup requests
// and APB register writes, and predicts hit, way, eviction and totals per request.
// Depends on sact_pkg and the set_assoc_cache_tag_lookup RTL.
module tb_set_assoc_cache_tag_lookup;
  import sact_pkg::*;

  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic                 hit;
    logic [WAY_O_W-1:0]   way;
    logic                 replaced;
    logic [TOTAL_W-1:0]   hit_total;
    logic [TOTAL_W-1:0]   miss_total;
  } lookup_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic [ADDR_W-1:0]   address_i;
  logic                done_o;
  logic                hit_o;
  logic [WAY_O_W-1:0]  way_o;
  logic                replaced_valid_o;
  logic [TOTAL_W-1:0]  hit_total_o;
  logic [TOTAL_W-1:0]  miss_total_o;

  // Register shadow
  sact_policy_e        cfg_policy;
  logic [3:0]          cfg_offset;
  logic [2:0]          cfg_index;
  logic [3:0]          cfg_ways;

  // Tag store shadow
  bit                  line_ok    [MAX_SETS][MAX_WAYS];
  logic [TAG_W-1:0]    tag_store  [MAX_SETS][MAX_WAYS];
  logic [31:0]         lru_stamp  [MAX_SETS][MAX_WAYS];
  logic [31:0]         fill_stamp [MAX_SETS][MAX_WAYS];
  logic [31:0]         use_clock;
  logic [31:0]         shadow_hits;
  logic [31:0]         shadow_misses;

  lookup_result_t      expected_lookups[$];
  int                  mismatches;
  int                  stall_cycles;
  bit                  no_idle;

  set_assoc_cache_tag_lookup uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .address_i        (address_i),
    .done_o           (done_o),
    .hit_o            (hit_o),
    .way_o            (way_o),
    .replaced_valid_o (replaced_valid_o),
    .hit_total_o      (hit_total_o),
    .miss_total_o     (miss_total_o)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Work out the result of one lookup and update the shadow store
  function automatic void predict_lookup(input logic [31:0] addr);
    int             ways;
    int             set_no;
    int             target;
    int             w;
    int             shift;
    logic [31:0]    tag;
    logic [31:0]    oldest;
    logic [31:0]    stamp;
    bit             found;
    lookup_result_t r;
    ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
    shift = int'(cfg_offset) + int'(cfg_index);
    set_no = int'((addr >> cfg_offset) & ((32'd1 << cfg_index) - 32'd1)) % MAX_SETS;
    tag = addr >> shift;
    target = 0;
    found = 1'b0;
    r = '0;
    if (use_clock != '1) use_clock++;
    for (w = 0; w < ways && !found; w++) begin
      if (line_ok[set_no][w] && tag_store[set_no][w] == tag) begin
        target = w;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (shadow_hits != '1) shadow_hits++;
      if (cfg_policy == POLICY_LRU) lru_stamp[set_no][target] = use_clock;
    end else begin
      if (shadow_misses != '1) shadow_misses++;
      for (w = 0; w < ways && !found; w++) begin
        if (!line_ok[set_no][w]) begin
          target = w;
          found = 1'b1;
        end
      end
      // Full set: evict the oldest stamp, lowest way on ties
      if (!found) begin
        target = 0;
        oldest = (cfg_policy == POLICY_LRU) ? lru_stamp[set_no][0] : fill_stamp[set_no][0];
        for (w = 1; w < ways; w++) begin
          stamp = (cfg_policy == POLICY_LRU) ? lru_stamp[set_no][w] : fill_stamp[set_no][w];
          if (stamp < oldest) begin
            oldest = stamp;
            target = w;
          end
        end
        r.replaced = 1'b1;
      end
      line_ok[set_no][target] = 1'b1;
      tag_store[set_no][target] = tag;
      fill_stamp[set_no][target] = use_clock;
      lru_stamp[set_no][target] = use_clock;
    end
    r.way = target[WAY_O_W-1:0];
    r.hit_total = shadow_hits;
    r.miss_total = shadow_misses;
    expected_lookups.push_back(r);
  endfunction

  // Issue one request; called at a falling edge, returns at a falling edge
  task automatic send_lookup(input logic [31:0] addr);
    start = 1'b1;
    address_i = addr;
    do @(posedge clk_i); while (busy);
    predict_lookup(addr);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(99) < 25) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // Drop start and wait until every expected result has arrived
  task automatic drain_lookups();
    start = 1'b0;
    while (expected_lookups.size() != 0 || busy) @(negedge clk_i);
  endtask

  // APB read; returns at a falling edge
  task automatic read_reg(input sact_reg_e idx, output logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b0;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Compare a register read with the shadow
  task automatic check_reg(input sact_reg_e idx);
    logic [31:0] got;
    logic [31:0] want;
    read_reg(idx, got);
    case (idx)
      REG_POLICY:      want = 32'(cfg_policy);
      REG_OFFSET_BITS: want = 32'(cfg_offset);
      REG_INDEX_BITS:  want = 32'(cfg_index);
      default:         want = 32'(cfg_ways);
    endcase
    if (got !== want) begin
      $display("%0t: register %s read expected %0h actual %0h", $time, idx.name(), want, got);
      mismatches++;
    end
  endtask

  // APB write with junk above the field, then read back
  task automatic write_reg(input sact_reg_e idx, input int value);
    int width;
    case (idx)
      REG_POLICY:      width = 1;
      REG_INDEX_BITS:  width = 3;
      default:         width = 4;
    endcase
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = (32'(value) & ((32'd1 << width) - 1)) | ($urandom << width);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_POLICY:      cfg_policy = sact_policy_e'(pwdata[0]);
      REG_OFFSET_BITS: cfg_offset = pwdata[3:0];
      REG_INDEX_BITS:  cfg_index = pwdata[2:0];
      default:         cfg_ways = pwdata[3:0];
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    check_reg(idx);
  endtask

  // Reprogram the policy, the address split and the way count once the block is idle
  task automatic set_geometry(input sact_policy_e pol, input int off, input int idx,
                              input int ways);
    drain_lookups();
    write_reg(REG_POLICY, int'(pol));
    write_reg(REG_OFFSET_BITS, off);
    write_reg(REG_INDEX_BITS, idx);
    write_reg(REG_ACTIVE_WAYS, ways);
  endtask

  // Mostly a few tags over a few sets so that hits and evictions happen
  function automatic logic [31:0] make_address();
    int          pick;
    logic [31:0] tag;
    logic [31:0] set_field;
    logic [31:0] low;
    pick = $urandom_range(99);
    if (pick < 15) return $urandom;
    tag = (pick < 22) ? $urandom : 32'($urandom_range(0, 9));
    set_field = 32'($urandom_range(0, 3)) | (32'($urandom_range(0, 1)) << 6);
    set_field = set_field & ((32'd1 << cfg_index) - 32'd1);
    low = $urandom & ((32'd1 << cfg_offset) - 32'd1);
    return (tag << (int'(cfg_offset) + int'(cfg_index))) | (set_field << cfg_offset) | low;
  endfunction

  // Registers come up with their reset values
  task automatic test_reset_values();
    check_reg(REG_POLICY);
    check_reg(REG_OFFSET_BITS);
    check_reg(REG_INDEX_BITS);
    check_reg(REG_ACTIVE_WAYS);
  endtask

  // Cold miss, hit on the same line, and the all-ones address
  task automatic test_basic_lookup();
    send_lookup(32'h0000_0000);
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFFF);
  endtask

  // Same access pattern under both policies: LRU and FIFO pick different victims
  task automatic test_replacement_order();
    set_geometry(POLICY_LRU, 0, 0, 2);
    send_lookup(32'h0000_0010);
    send_lookup(32'h0000_0020);
    send_lookup(32'h0000_0010);
    send_lookup(32'h0000_0030);
    set_geometry(POLICY_FIFO, 0, 0, 2);
    send_lookup(32'h0000_0110);
    send_lookup(32'h0000_0120);
    send_lookup(32'h0000_0110);
    send_lookup(32'h0000_0130);
  endtask

  // Zero ways, ways above the store, set number wrapping, the widest split and a single way
  task automatic test_way_limits();
    set_geometry(POLICY_LRU, 2, 2, 0);
    send_lookup(32'h0000_0400);
    send_lookup(32'h0000_0800);
    set_geometry(POLICY_FIFO, 15, 7, 15);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h003F_8000);
    send_lookup(32'h0020_0000);
    set_geometry(POLICY_LRU, 12, 6, 1);
    send_lookup(32'h0000_0000);
    send_lookup(32'h1234_5000);
  endtask

  // Random traffic over a set of geometries, one stretch without idle gaps
  task automatic test_random_mix();
    int phase;
    int n;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_geometry(POLICY_LRU, 0, 0, 1);
        1: set_geometry(POLICY_FIFO, 4, 1, 2);
        2: set_geometry(POLICY_LRU, 6, 2, 4);
        3: set_geometry(POLICY_FIFO, 12, 6, 8);
        4: set_geometry(POLICY_LRU, 3, 3, 8);
        5: set_geometry(POLICY_FIFO, 15, 7, 15);
        default: set_geometry(sact_policy_e'($urandom_range(0, 1)), $urandom_range(0, 15),
                              $urandom_range(0, 7), $urandom_range(0, 15));
      endcase
      no_idle = (phase == 2);
      for (n = 0; n < 235; n++) send_lookup(make_address());
      no_idle = 1'b0;
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && done_o) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result hit=%0b way=%0d", $time, hit_o, way_o);
        mismatches++;
      end else begin
        want = expected_lookups.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit_o);
          mismatches++;
        end
        if (way_o !== want.way) begin
          $display("%0t: way expected %0d actual %0d", $time, want.way, way_o);
          mismatches++;
        end
        if (replaced_valid_o !== want.replaced) begin
          $display("%0t: replaced_valid expected %0b actual %0b", $time, want.replaced,
                   replaced_valid_o);
          mismatches++;
        end
        if (hit_total_o !== want.hit_total) begin
          $display("%0t: hit_total expected %0d actual %0d", $time, want.hit_total,
                   hit_total_o);
          mismatches++;
        end
        if (miss_total_o !== want.miss_total) begin
          $display("%0t: miss_total expected %0d actual %0d", $time, want.miss_total,
                   miss_total_o);
          mismatches++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_lookups.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    address_i = '0;
    mismatches = 0;
    stall_cycles = 0;
    no_idle = 1'b0;
    cfg_policy = POLICY_LRU;
    cfg_offset = 4'd4;
    cfg_index = 3'd1;
    cfg_ways = 4'd2;
    use_clock = '0;
    shadow_hits = '0;
    shadow_misses = '0;
    foreach (line_ok[s, w]) begin
      line_ok[s][w] = 1'b0;
      tag_store[s][w] = '0;
      lru_stamp[s][w] = '0;
      fill_stamp[s][w] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_basic_lookup();
    test_replacement_order();
    test_way_limits();
    test_random_mix();

    // Let the last results out, then report
    drain_lookups();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sact_pkg.sv
sv/sact_row_mem.sv
sv/set_assoc_cache_tag_lookup.sv
tb/sv/tb_set_assoc_cache_tag_lookup.sv
